### hw/rtl/eebm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eebm_pkg
// Shared types and constants for the I2C EEPROM byte master.
// ----------------------------------------------------------------------------
package eebm_pkg;

    // Input opcodes as they arrive on the stream
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W       = 1;
    localparam int         CFG_DATA_W      = 16;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_CYCLE = 1'b1;

    // Register reset values
    localparam logic [7:0]  HALF_BIT_RESET    = 8'd18;
    localparam logic [15:0] WRITE_CYCLE_RESET = 16'd100;

    // Stream widths
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    // Command class decided by the front end
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_READ,
        CMD_WRITE
    } cmd_t;

    // One classified tick as it travels through the queue
    typedef struct packed {
        cmd_t        cmd;
        logic [14:0] mem_address;
        logic [7:0]  write_byte;
        logic        sda_in;
    } item_t;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic [7:0]  half_bit_ticks;
        logic [15:0] write_cycle_ticks;
    } cfg_t;

    // Handshake between queue and sequencer
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

endpackage

### hw/rtl/eebm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eebm_front
// Input stage: unpacks the stream transaction and classifies the opcode.
// ----------------------------------------------------------------------------
module eebm_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [eebm_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [eebm_pkg::IN_USER_W-1:0] s_tuser,
    input  logic                          q_full,
    output logic                          push,
    output eebm_pkg::item_t               push_item
);
    import eebm_pkg::*;

    // Accept whenever the queue has room
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Classify the opcode; the unused code acts as a plain tick
    always_comb
    begin
        push_item.mem_address = s_tdata[14:0];
        push_item.write_byte  = s_tdata[22:15];
        push_item.sda_in      = s_tdata[23];
        unique case (s_tuser)
            OP_READ:  push_item.cmd = CMD_READ;
            OP_WRITE: push_item.cmd = CMD_WRITE;
            default:  push_item.cmd = CMD_NONE;
        endcase
    end

endmodule

### hw/rtl/eebm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eebm_queue
// Two-entry queue between the input stage and the bus sequencer.
// ----------------------------------------------------------------------------
module eebm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  eebm_pkg::item_t   push_item,
    output logic              full,
    input  logic              pop,
    output eebm_pkg::q_head_t head
);
    import eebm_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### hw/rtl/eebm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eebm_back
// Bus sequencer: one queued tick per step, result held in an output register.
// ----------------------------------------------------------------------------
module eebm_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  eebm_pkg::cfg_t                 cfg,
    input  eebm_pkg::q_head_t              head,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [eebm_pkg::OUT_DATA_W-1:0] m_tdata
);
    import eebm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START1, ST_CTRLW, ST_ADDRH, ST_ADDRL, ST_DATA,
        ST_START2, ST_CTRLR, ST_READ, ST_STOP, ST_STOPF, ST_WAIT
    } state_t;

    state_t      state_reg,  state_next;
    logic        half_reg,   half_next;
    logic [3:0]  bit_reg,    bit_next;
    logic [7:0]  phase_reg,  phase_next;
    logic [15:0] wait_reg,   wait_next;
    logic [7:0]  shift_reg,  shift_next;
    logic [14:0] addr_reg,   addr_next;
    logic [7:0]  data_reg,   data_next;
    logic        wr_reg,     wr_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg,  m_tdata_next;

    state_t      st_e;
    logic        half_e;
    logic [3:0]  bit_e;
    logic [7:0]  phase_e;
    logic [15:0] wait_e;
    logic [7:0]  shift_e;
    logic [7:0]  tx;
    logic [7:0]  limit;
    logic        scl, sda, drv, busy, done, fail;
    logic [7:0]  rb;

    // Take a tick when the output register is free or being emptied
    assign pop      = head.valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign limit    = (cfg.half_bit_ticks == 8'd0) ? 8'd1 : cfg.half_bit_ticks;

    // Following byte stage after an acknowledged byte
    function automatic state_t after_byte(input state_t s, input logic w);
        state_t r;
        unique case (s)
            ST_CTRLW: r = ST_ADDRH;
            ST_ADDRH: r = ST_ADDRL;
            ST_ADDRL: r = w ? ST_DATA : ST_START2;
            ST_CTRLR: r = ST_READ;
            default:  r = ST_STOP;
        endcase
        return r;
    endfunction

    always_comb
    begin
        // Latch a command when idle
        st_e      = state_reg;
        half_e    = half_reg;
        bit_e     = bit_reg;
        phase_e   = phase_reg;
        wait_e    = wait_reg;
        shift_e   = shift_reg;
        addr_next = addr_reg;
        data_next = data_reg;
        wr_next   = wr_reg;
        if (state_reg == ST_IDLE && head.item.cmd != CMD_NONE)
        begin
            addr_next = head.item.mem_address;
            data_next = head.item.write_byte;
            wr_next   = (head.item.cmd == CMD_WRITE);
            shift_e   = 8'd0;
            wait_e    = 16'd0;
            st_e      = ST_START1;
            half_e    = 1'b0;
            bit_e     = 4'd0;
            phase_e   = 8'd0;
        end

        // Select the byte on the wire
        unique case (st_e)
            ST_CTRLW: tx = {4'b1010, 1'b0, addr_next[14:13], 1'b0};
            ST_CTRLR: tx = {4'b1010, 1'b0, addr_next[14:13], 1'b1};
            ST_ADDRH: tx = {3'b000, addr_next[12:8]};
            ST_ADDRL: tx = addr_next[7:0];
            default:  tx = data_next;
        endcase

        // Drive the bus levels
        scl  = 1'b1;
        sda  = 1'b1;
        drv  = 1'b0;
        busy = (st_e != ST_IDLE);
        done = 1'b0;
        fail = 1'b0;
        rb   = 8'd0;
        unique case (st_e)
            ST_START1, ST_START2:
            begin
                drv = 1'b1;
                scl = (bit_e != 4'd0);
                sda = (bit_e < 4'd2);
            end
            ST_STOP, ST_STOPF:
            begin
                drv = 1'b1;
                scl = (bit_e != 4'd0);
                sda = (bit_e >= 4'd2);
            end
            ST_CTRLW, ST_ADDRH, ST_ADDRL, ST_DATA, ST_CTRLR:
            begin
                scl = half_e;
                if (bit_e < 4'd8)
                begin
                    drv = 1'b1;
                    sda = tx[~bit_e[2:0]];
                end
            end
            ST_READ:
            begin
                scl = half_e;
                drv = (bit_e >= 4'd8);
            end
            default:
            begin
            end
        endcase

        // Advance timing and sequence
        state_next = st_e;
        half_next  = half_e;
        bit_next   = bit_e;
        phase_next = phase_e;
        wait_next  = wait_e;
        shift_next = shift_e;
        if (st_e == ST_WAIT)
        begin
            if ({1'b0, wait_e} + 17'd1 >= {1'b0, cfg.write_cycle_ticks})
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
                half_next  = 1'b0;
                bit_next   = 4'd0;
                phase_next = 8'd0;
            end
            else
                wait_next = wait_e + 16'd1;
        end
        else if (st_e != ST_IDLE)
        begin
            if ({1'b0, phase_e} + 9'd1 < {1'b0, limit})
                phase_next = phase_e + 8'd1;
            else
            begin
                phase_next = 8'd0;
                if (st_e == ST_START1 || st_e == ST_START2 ||
                    st_e == ST_STOP || st_e == ST_STOPF)
                begin
                    if (bit_e < 4'd2)
                        bit_next = bit_e + 4'd1;
                    else
                    begin
                        half_next = 1'b0;
                        bit_next  = 4'd0;
                        if (st_e == ST_START1)
                            state_next = ST_CTRLW;
                        else if (st_e == ST_START2)
                            state_next = ST_CTRLR;
                        else if (st_e == ST_STOPF)
                        begin
                            done       = 1'b1;
                            fail       = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else if (wr_next && cfg.write_cycle_ticks != 16'd0)
                        begin
                            wait_next  = 16'd0;
                            state_next = ST_WAIT;
                        end
                        else
                        begin
                            done       = 1'b1;
                            rb         = wr_next ? 8'd0 : shift_e;
                            state_next = ST_IDLE;
                        end
                    end
                end
                else if (!half_e)
                    half_next = 1'b1;
                else
                begin
                    half_next = 1'b0;
                    if (bit_e < 4'd8)
                    begin
                        if (st_e == ST_READ)
                            shift_next = {shift_e[6:0], head.item.sda_in};
                        bit_next = bit_e + 4'd1;
                    end
                    else
                    begin
                        bit_next = 4'd0;
                        if (st_e == ST_READ)
                            state_next = ST_STOP;
                        else if (head.item.sda_in)
                            state_next = ST_STOPF;
                        else
                            state_next = after_byte(st_e, wr_next);
                    end
                end
            end
        end

        // Pack the result and manage the output register
        m_tdata_next  = {rb, fail, done, busy, addr_next[14:13], drv, sda, scl};
        m_tvalid_next = pop ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    // Hold sequencer state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            half_reg     <= 1'b0;
            bit_reg      <= 4'd0;
            phase_reg    <= 8'd0;
            wait_reg     <= 16'd0;
            shift_reg    <= 8'd0;
            addr_reg     <= 15'd0;
            data_reg     <= 8'd0;
            wr_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (pop)
            begin
                state_reg   <= state_next;
                half_reg    <= half_next;
                bit_reg     <= bit_next;
                phase_reg   <= phase_next;
                wait_reg    <= wait_next;
                shift_reg   <= shift_next;
                addr_reg    <= addr_next;
                data_reg    <= data_next;
                wr_reg      <= wr_next;
                m_tdata_reg <= m_tdata_next;
            end
        end
    end

endmodule

### hw/rtl/i2c_eeprom_byte_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master
// I2C master for a serial EEPROM: random byte read and byte write, one tick
// per stream transaction.
//
//   Channel  Direction  Contents
//   s_*      in         tuser: opcode; tdata: mem_address, write_byte, sda_in
//   m_*      out        tdata: scl/sda levels, drive, bank, busy, done, fail,
//                       read_byte
//   cfg_*    in         index 0 half_bit_ticks, index 1 write_cycle_ticks
//
// One transaction in, one transaction out; one tick taken per clock while the
// output is not stalled. A result is registered in the output register once
// its tick leaves the queue, and is held there while the output stalls. The
// two-entry queue buffers up to two more ticks behind a stalled result, after
// which the input stalls. Reset is asynchronous and clears the sequencer, the
// queue and the registers to their defaults.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_master (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [14:0] mem_address, [22:15] write_byte, [23] sda_in
    input  logic [eebm_pkg::IN_DATA_W-1:0]   s_tdata,
    // [1:0] opcode
    input  logic [eebm_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] scl_level, [1] sda_level, [2] sda_drive, [4:3] bank_pins,
    // [5] busy_res, [6] done_res, [7] failed, [15:8] read_byte
    output logic [eebm_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_we,
    input  logic [eebm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [eebm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import eebm_pkg::*;

    cfg_t    cfg_reg;
    logic    q_full;
    logic    push;
    item_t   push_item;
    logic    pop;
    q_head_t head;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_bit_ticks    <= HALF_BIT_RESET;
            cfg_reg.write_cycle_ticks <= WRITE_CYCLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HALF_BIT:    cfg_reg.half_bit_ticks    <= cfg_wdata[7:0];
                REG_WRITE_CYCLE: cfg_reg.write_cycle_ticks <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    eebm_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    eebm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    eebm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### hw/rtl/eebm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eebm_checker
// Port-level checks on the result stream of the EEPROM byte master.
// ----------------------------------------------------------------------------
module eebm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [eebm_pkg::OUT_DATA_W-1:0] m_tdata
);
    import eebm_pkg::*;

    // A failure is only reported on the done tick
    a_fail_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[7]) |-> m_tdata[6])
        else $error("failed without done");

    // Done always falls inside a busy window
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[6]) |-> m_tdata[5])
        else $error("done while not busy");

    // Released SDA reads as high level
    a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[2]) |-> m_tdata[1])
        else $error("sda level low while released");

    // Read data appears only with done
    a_rb_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[6]) |-> (m_tdata[15:8] == 8'd0))
        else $error("read byte outside done");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed under stall");

endmodule

bind i2c_eeprom_byte_master eebm_checker u_eebm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
